FILE: rtl/core/slewed_time_of_day_clock_top_macros.svh
// Assertion macros for the slewed time-of-day clock.
`ifndef SLEWED_TIME_OF_DAY_CLOCK_TOP_MACROS_SVH
`define SLEWED_TIME_OF_DAY_CLOCK_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define STDC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define STDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: rtl/core/stdc_pkg.sv
// Package: codes, widths and constants of the slewed time-of-day clock.
`default_nettype none
package stdc_pkg;

    // Field widths
    localparam int OPCODE_W    = 3;
    localparam int SEC_W       = 32;
    localparam int USEC_IN_W   = 21;
    localparam int COUNTDOWN_W = 20;
    localparam int USEC_W      = 22;
    localparam int RES_W       = 21;
    localparam int RTC_W       = 21;
    localparam int STEP_W      = 16;
    localparam int TRIM_W      = 12;
    localparam int SUM_W       = 24;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_USEC      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REMAINDER_TRIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRIM_ENABLE    = 2'd2;

    typedef logic [OPCODE_W-1:0] t_opcode;

    localparam t_opcode OP_TICK     = 3'd0;
    localparam t_opcode OP_LOAD_RES = 3'd1;
    localparam t_opcode OP_STEP_ADJ = 3'd2;
    localparam t_opcode OP_ARM_RTC  = 3'd3;
    localparam t_opcode OP_READ     = 3'd4;

    localparam int DEF_STEPS_PER_SECOND = 2000;

    // Reset values
    localparam logic [STEP_W-1:0]        STEP_USEC_RST = 16'd500;
    localparam logic signed [USEC_W-1:0] USEC_RST      = 22'sd250000;

    // Arithmetic limits
    localparam logic signed [RES_W-1:0] SLEW_LIMIT   = 21'sd250;
    localparam logic signed [SUM_W-1:0] USEC_PER_SEC = 24'sd1000000;
    localparam logic signed [SUM_W-1:0] USEC_SAT_LOW  = -24'sd1000000;
    localparam logic signed [SUM_W-1:0] USEC_SAT_HIGH = 24'sd1999999;

endpackage
`default_nettype wire

FILE: rtl/core/slewed_time_of_day_clock_top.sv
// Top level: slewed time-of-day clock with step trim, dither, slew and RTC countdown.
//
// Usage
//  - Input channel (i_in_valid / o_in_stall) carries one command per transfer:
//    tick, load residual, step adjust, arm RTC write, or read.
//  - Output channel (o_out_valid / i_out_stall) returns one result per command:
//    seconds and microseconds after the command, and the RTC fire flag.
//  - Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
//    (0 step_usec, 1 remainder_trim, 2 trim_enable) at the clock edge; write
//    only while no command is in flight.
//  - Result: registered, and shown in the cycle after the input transfer.
//  - Throughput: one command per cycle unless stalled; the whole update is one
//    adder/compare stage between the clock state registers and the result register.
//  - Stall: the result register holds while i_out_stall is high; the input is
//    stalled only when the result register is full and the receiver stalls.
//  - Reset (synchronous, active low): time 0 s / 250000 us, epoch at
//    STEPS_PER_SECOND, residual and countdown cleared, step_usec 500,
//    trim off; no result pending.
`default_nettype none
`include "slewed_time_of_day_clock_top_macros.svh"
module slewed_time_of_day_clock_top #(
    parameter int STEPS_PER_SECOND = stdc_pkg::DEF_STEPS_PER_SECOND
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // command channel
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_stall,
    input  wire stdc_pkg::t_opcode                      i_opcode,
    input  wire logic signed [stdc_pkg::SEC_W-1:0]      i_sec_delta,
    input  wire logic signed [stdc_pkg::USEC_IN_W-1:0]  i_usec_value,
    input  wire logic [stdc_pkg::COUNTDOWN_W-1:0]       i_countdown_usec,
    // result channel
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_stall,
    output logic [stdc_pkg::SEC_W-1:0]                  o_seconds,
    output logic signed [stdc_pkg::USEC_W-1:0]          o_micros,
    output logic                                        o_rtc_fire,
    // configuration write port
    input  wire logic                                   i_cfg_we,
    input  wire logic [stdc_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [stdc_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import stdc_pkg::*;

    // Epoch counter holds 1..STEPS_PER_SECOND
    localparam int EPOCH_W = $clog2(STEPS_PER_SECOND + 1);
    // Signed compare width covering the epoch value and the negated trim
    localparam int CMP_W   = ((EPOCH_W > TRIM_W) ? EPOCH_W : TRIM_W) + 2;
    localparam logic [EPOCH_W-1:0] EPOCH_RELOAD = EPOCH_W'(STEPS_PER_SECOND);

    // configuration registers
    logic [STEP_W-1:0]        r_step_usec;
    logic signed [TRIM_W-1:0] r_remainder_trim;
    logic                     r_trim_enable;

    // clock state
    logic [SEC_W-1:0]         r_sec_count,     n_sec_count;
    logic signed [USEC_W-1:0] r_usec_count,    n_usec_count;
    logic [EPOCH_W-1:0]       r_epoch_count,   n_epoch_count;
    logic signed [RES_W-1:0]  r_residual,      n_residual;
    logic                     r_rtc_pending,   n_rtc_pending;
    logic signed [RTC_W-1:0]  r_rtc_countdown, n_rtc_countdown;
    logic                     n_fire;

    // result register
    logic                     r_out_valid;
    logic [SEC_W-1:0]         r_seconds;
    logic signed [USEC_W-1:0] r_micros;
    logic                     r_rtc_fire;

    logic in_xfer;

    // tick datapath
    logic signed [RTC_W-1:0]  tick_countdown;
    logic                     tick_fire;
    logic [EPOCH_W-1:0]       epoch_dec;
    logic signed [CMP_W-1:0]  epoch_cmp;
    logic signed [CMP_W-1:0]  trim_cmp;
    logic signed [CMP_W-1:0]  trim_neg;
    logic signed [SUM_W-1:0]  dither;
    logic signed [RES_W-1:0]  slew;
    logic signed [SUM_W-1:0]  tick_sum;
    logic signed [SUM_W-1:0]  adj_sum;

    // handshake: the result register frees up when its transfer completes
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_xfer    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_usec      <= STEP_USEC_RST;
            r_remainder_trim <= '0;
            r_trim_enable    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_STEP_USEC:      r_step_usec      <= i_cfg_data[STEP_W-1:0];
                REG_REMAINDER_TRIM: r_remainder_trim <= signed'(i_cfg_data[TRIM_W-1:0]);
                REG_TRIM_ENABLE:    r_trim_enable    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // RTC countdown: fires once it reaches zero or below
    assign tick_countdown = r_rtc_countdown - signed'(RTC_W'(r_step_usec));
    assign tick_fire      = r_rtc_pending && (tick_countdown <= 0);

    // Dither over the epoch; none on the reload tick
    assign epoch_dec = r_epoch_count - 1'b1;
    assign epoch_cmp = signed'({{(CMP_W-EPOCH_W){1'b0}}, epoch_dec});
    assign trim_cmp  = {{(CMP_W-TRIM_W){r_remainder_trim[TRIM_W-1]}}, r_remainder_trim};
    assign trim_neg  = -trim_cmp;

    always_comb begin
        dither = '0;
        if (r_trim_enable && (epoch_dec != '0)) begin
            if (epoch_cmp <= trim_cmp) begin
                dither = SUM_W'(1);
            end else if (epoch_cmp <= trim_neg) begin
                dither = -SUM_W'(1);
            end
        end
    end

    // Slew of the residual, clamped
    always_comb begin
        if (r_residual > SLEW_LIMIT) begin
            slew = SLEW_LIMIT;
        end else if (r_residual < -SLEW_LIMIT) begin
            slew = -SLEW_LIMIT;
        end else begin
            slew = r_residual;
        end
    end

    assign tick_sum = SUM_W'(r_usec_count) + signed'(SUM_W'(r_step_usec)) + dither
                    + SUM_W'(slew);
    assign adj_sum  = SUM_W'(r_usec_count) + SUM_W'(i_usec_value);

    always_comb begin
        n_sec_count     = r_sec_count;
        n_usec_count    = r_usec_count;
        n_epoch_count   = r_epoch_count;
        n_residual      = r_residual;
        n_rtc_pending   = r_rtc_pending;
        n_rtc_countdown = r_rtc_countdown;
        n_fire          = 1'b0;
        case (i_opcode)
            OP_TICK: begin
                if (r_rtc_pending) begin
                    n_rtc_countdown = tick_countdown;
                end
                if (tick_fire) begin
                    n_rtc_pending = 1'b0;
                end
                n_fire = tick_fire;
                if (r_trim_enable) begin
                    n_epoch_count = (epoch_dec == '0) ? EPOCH_RELOAD : epoch_dec;
                end
                n_residual = r_residual - slew;
                // single carry in either direction
                if (tick_sum < 0) begin
                    n_sec_count  = r_sec_count - 1'b1;
                    n_usec_count = USEC_W'(tick_sum + USEC_PER_SEC);
                end else if (tick_sum >= USEC_PER_SEC) begin
                    n_sec_count  = r_sec_count + 1'b1;
                    n_usec_count = USEC_W'(tick_sum - USEC_PER_SEC);
                end else begin
                    n_usec_count = USEC_W'(tick_sum);
                end
            end
            OP_LOAD_RES: begin
                n_residual = i_usec_value;
            end
            OP_STEP_ADJ: begin
                // saturate, carry deferred to next tick
                if (adj_sum < USEC_SAT_LOW) begin
                    n_usec_count = USEC_W'(USEC_SAT_LOW);
                end else if (adj_sum > USEC_SAT_HIGH) begin
                    n_usec_count = USEC_W'(USEC_SAT_HIGH);
                end else begin
                    n_usec_count = USEC_W'(adj_sum);
                end
                n_sec_count = r_sec_count + i_sec_delta;
            end
            OP_ARM_RTC: begin
                n_rtc_countdown = signed'(RTC_W'(i_countdown_usec));
                n_rtc_pending   = 1'b1;
            end
            OP_READ: begin
            end
            default: begin
                // spare codes read only
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec_count     <= '0;
            r_usec_count    <= USEC_RST;
            r_epoch_count   <= EPOCH_RELOAD;
            r_residual      <= '0;
            r_rtc_pending   <= 1'b0;
            r_rtc_countdown <= '0;
        end else if (in_xfer) begin
            r_sec_count     <= n_sec_count;
            r_usec_count    <= n_usec_count;
            r_epoch_count   <= n_epoch_count;
            r_residual      <= n_residual;
            r_rtc_pending   <= n_rtc_pending;
            r_rtc_countdown <= n_rtc_countdown;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_seconds  <= n_sec_count;
            r_micros   <= n_usec_count;
            r_rtc_fire <= n_fire;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_seconds   = r_seconds;
    assign o_micros    = r_micros;
    assign o_rtc_fire  = r_rtc_fire;

    // epoch never sits at zero and never passes the reload value
    `STDC_ASSERT_NOW(a_epoch_range, i_clk, i_rst_n, 1'b1, (r_epoch_count != '0) && (r_epoch_count <= EPOCH_RELOAD))
    // microseconds stay inside the saturation window
    `STDC_ASSERT_NOW(a_usec_range, i_clk, i_rst_n, 1'b1, (SUM_W'(r_usec_count) >= USEC_SAT_LOW) && (SUM_W'(r_usec_count) <= USEC_SAT_HIGH))
    // only a tick can raise the fire flag
    `STDC_ASSERT_NEXT(a_fire_on_tick, i_clk, i_rst_n, in_xfer && (i_opcode != OP_TICK), !o_rtc_fire)
    // a fire disarms the countdown
    `STDC_ASSERT_NEXT(a_fire_disarms, i_clk, i_rst_n, in_xfer && n_fire, !r_rtc_pending && o_rtc_fire)

endmodule
`default_nettype wire

FILE: tb/slewed_time_of_day_clock_checker.sv
// Checker for the slewed time-of-day clock: watches both channels, predicts and compares.
module slewed_time_of_day_clock_checker #(
    parameter int STEPS_PER_SECOND = stdc_pkg::DEF_STEPS_PER_SECOND
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_in_valid,
    input  wire logic                                   i_in_stall,
    input  wire stdc_pkg::t_opcode                      i_opcode,
    input  wire logic signed [stdc_pkg::SEC_W-1:0]      i_sec_delta,
    input  wire logic signed [stdc_pkg::USEC_IN_W-1:0]  i_usec_value,
    input  wire logic [stdc_pkg::COUNTDOWN_W-1:0]       i_countdown_usec,
    input  wire logic                                   i_out_valid,
    input  wire logic                                   i_out_stall,
    input  wire logic [stdc_pkg::SEC_W-1:0]             i_seconds,
    input  wire logic signed [stdc_pkg::USEC_W-1:0]     i_micros,
    input  wire logic                                   i_rtc_fire,
    input  wire logic                                   i_cfg_we,
    input  wire logic [stdc_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [stdc_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    output int                                          o_fail_count,
    output int                                          o_pending
);
    import stdc_pkg::*;

    localparam int    SLEW_CAP     = int'(SLEW_LIMIT);
    localparam longint ONE_SECOND  = longint'(USEC_PER_SEC);
    localparam longint MICROS_LOW  = longint'(USEC_SAT_LOW);
    localparam longint MICROS_HIGH = longint'(USEC_SAT_HIGH);

    typedef struct {
        logic [SEC_W-1:0]         seconds;
        logic signed [USEC_W-1:0] micros;
        logic                     rtc_fire;
    } t_time_result;

    t_time_result expected_times[$];

    // configuration registers
    logic [STEP_W-1:0]        step_usec;
    logic signed [TRIM_W-1:0] rem_trim;
    logic                     trim_on;

    // clock state
    logic [SEC_W-1:0] sec_count;
    int               usec_count;
    int               epoch_count;
    int               residual;
    logic             rtc_armed;
    int               countdown;

    function automatic t_time_result advance_clock(
        input t_opcode                      op,
        input logic signed [SEC_W-1:0]      sec_delta,
        input logic signed [USEC_IN_W-1:0]  usec_value,
        input logic [COUNTDOWN_W-1:0]       countdown_usec
    );
        t_time_result r;
        int           dither;
        int           slew;
        longint       t;
        r.rtc_fire = 1'b0;
        dither = 0;
        case (op)
            OP_TICK: begin
                if (rtc_armed) begin
                    countdown = countdown - int'(step_usec);
                    if (countdown <= 0) begin
                        r.rtc_fire = 1'b1;
                        rtc_armed = 1'b0;
                    end
                end
                if (trim_on) begin
                    epoch_count = epoch_count - 1;
                    if (epoch_count == 0)
                        epoch_count = STEPS_PER_SECOND;
                    else if (epoch_count <= int'(rem_trim))
                        dither = 1;
                    else if (epoch_count <= -int'(rem_trim))
                        dither = -1;
                end
                if (residual > SLEW_CAP)
                    slew = SLEW_CAP;
                else if (residual < -SLEW_CAP)
                    slew = -SLEW_CAP;
                else
                    slew = residual;
                residual = residual - slew;
                t = longint'(usec_count) + longint'(step_usec) + dither + slew;
                if (t < 0) begin
                    sec_count = sec_count - 1;
                    t = t + ONE_SECOND;
                end else if (t >= ONE_SECOND) begin
                    sec_count = sec_count + 1;
                    t = t - ONE_SECOND;
                end
                usec_count = int'(t);
            end
            OP_LOAD_RES: residual = int'(usec_value);
            OP_STEP_ADJ: begin
                t = longint'(usec_count) + longint'(usec_value);
                if (t < MICROS_LOW)
                    t = MICROS_LOW;
                if (t > MICROS_HIGH)
                    t = MICROS_HIGH;
                usec_count = int'(t);
                sec_count = sec_count + sec_delta;
            end
            OP_ARM_RTC: begin
                countdown = int'(countdown_usec);
                rtc_armed = 1'b1;
            end
            default: ;
        endcase
        r.seconds = sec_count;
        r.micros = usec_count[USEC_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_time_result want;
        if (!i_rst_n) begin
            step_usec = STEP_USEC_RST;
            rem_trim = '0;
            trim_on = 1'b0;
            sec_count = '0;
            usec_count = int'(USEC_RST);
            epoch_count = STEPS_PER_SECOND;
            residual = 0;
            rtc_armed = 1'b0;
            countdown = 0;
            expected_times.delete();
            o_fail_count = 0;
        end else begin
            // result side first, so a transfer in this cycle cannot hide a stray result
            if (i_out_valid && !i_out_stall) begin
                if (expected_times.size() == 0) begin
                    $error("result with nothing expected: seconds %0d micros %0d fire %0d",
                           i_seconds, i_micros, i_rtc_fire);
                    o_fail_count++;
                end else begin
                    want = expected_times.pop_front();
                    if (i_seconds !== want.seconds) begin
                        $error("seconds: expected %0d, actual %0d", want.seconds, i_seconds);
                        o_fail_count++;
                    end
                    if (i_micros !== want.micros) begin
                        $error("micros: expected %0d, actual %0d", want.micros, i_micros);
                        o_fail_count++;
                    end
                    if (i_rtc_fire !== want.rtc_fire) begin
                        $error("rtc_fire: expected %0d, actual %0d", want.rtc_fire, i_rtc_fire);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_times.push_back(advance_clock(i_opcode, i_sec_delta, i_usec_value,
                                                       i_countdown_usec));
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_STEP_USEC:      step_usec = i_cfg_data[STEP_W-1:0];
                    REG_REMAINDER_TRIM: rem_trim = i_cfg_data[TRIM_W-1:0];
                    REG_TRIM_ENABLE:    trim_on = i_cfg_data[0];
                    default: ;
                endcase
            end
        end
        o_pending = expected_times.size();
    end

endmodule

FILE: tb/tb_slewed_time_of_day_clock_top.sv
// Testbench top for the slewed time-of-day clock: stimulus, idling and verdict.
module tb_slewed_time_of_day_clock_top;
    import stdc_pkg::*;

    localparam int STEPS        = DEF_STEPS_PER_SECOND;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int CHUNKS       = 7;      // random chunks of commands
    localparam int CHUNK_ITEMS  = 100;

    // index past the last register, and the top of the unused opcode space
    localparam logic [CFG_IDX_W-1:0] REG_SPARE     = 2'd3;
    localparam t_opcode              OP_SPARE_LAST = 3'd7;

    // idling per chunk: none, sender gaps, receiver stalls, both lightly
    int send_gap_pct[4] = '{0, 61, 0, 10};
    int recv_gap_pct[4] = '{0, 0, 61, 10};

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // command channel
    logic                        cmd_valid = 1'b0;
    logic                        cmd_stall;
    t_opcode                     cmd_opcode = OP_READ;
    logic signed [SEC_W-1:0]     cmd_sec_delta = '0;
    logic signed [USEC_IN_W-1:0] cmd_usec_value = '0;
    logic [COUNTDOWN_W-1:0]      cmd_countdown = '0;

    // result channel
    logic                        res_valid;
    logic                        res_stall = 1'b0;
    logic [SEC_W-1:0]            res_seconds;
    logic signed [USEC_W-1:0]    res_micros;
    logic                        res_rtc_fire;

    // configuration port
    logic                        cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]        cfg_index = REG_STEP_USEC;
    logic [CFG_DATA_W-1:0]       cfg_data = '0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cycle_count = 0;
    int fail_count;
    int pending_results;

    slewed_time_of_day_clock_top #(
        .STEPS_PER_SECOND (STEPS)
    ) u_top (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (cmd_valid),
        .o_in_stall       (cmd_stall),
        .i_opcode         (cmd_opcode),
        .i_sec_delta      (cmd_sec_delta),
        .i_usec_value     (cmd_usec_value),
        .i_countdown_usec (cmd_countdown),
        .o_out_valid      (res_valid),
        .i_out_stall      (res_stall),
        .o_seconds        (res_seconds),
        .o_micros         (res_micros),
        .o_rtc_fire       (res_rtc_fire),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    slewed_time_of_day_clock_checker #(
        .STEPS_PER_SECOND (STEPS)
    ) u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (cmd_valid),
        .i_in_stall       (cmd_stall),
        .i_opcode         (cmd_opcode),
        .i_sec_delta      (cmd_sec_delta),
        .i_usec_value     (cmd_usec_value),
        .i_countdown_usec (cmd_countdown),
        .i_out_valid      (res_valid),
        .i_out_stall      (res_stall),
        .i_seconds        (res_seconds),
        .i_micros         (res_micros),
        .i_rtc_fire       (res_rtc_fire),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending_results)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    // Receiver: stalls at random, at the rate of the current chunk.
    always @(posedge clk)
        res_stall <= ($urandom_range(99) < recv_stall_pct);

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("slewed_time_of_day_clock_top test failed");
            $finish;
        end
    end

    // One command transfer. Valid is left high on return, so back-to-back
    // transfers never lower and raise it in the same step; a gap lowers it.
    task automatic send_cmd(input t_opcode op, input logic [SEC_W-1:0] sec_delta,
                            input logic [USEC_IN_W-1:0] usec_value,
                            input logic [COUNTDOWN_W-1:0] countdown);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid      <= 1'b1;
        cmd_opcode     <= op;
        cmd_sec_delta  <= sec_delta;
        cmd_usec_value <= usec_value;
        cmd_countdown  <= countdown;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
    endtask

    // Sender holds off until every result has been taken. The first edge lets
    // the checker log the last transfer before its count is looked at.
    task automatic drain_results;
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Configuration writes: only with the block idle. The spare index is
    // written too; it must leave the clock alone.
    task automatic write_settings(input logic [STEP_W-1:0] step,
                                  input logic [TRIM_W-1:0] trim, input logic enable);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= REG_STEP_USEC;
        cfg_data  <= step;
        @(posedge clk);
        cfg_index <= REG_REMAINDER_TRIM;
        cfg_data  <= {4'($urandom), trim};
        @(posedge clk);
        cfg_index <= REG_TRIM_ENABLE;
        cfg_data  <= {15'($urandom), enable};
        @(posedge clk);
        cfg_index <= REG_SPARE;
        cfg_data  <= 16'($urandom);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Mostly ticks so the slew, dither and countdown get deep; the other
    // opcodes keep loading residual, stepping the time and re-arming.
    task automatic send_random_cmd;
        int                     pick;
        t_opcode                op;
        logic [SEC_W-1:0]       sd;
        logic [USEC_IN_W-1:0]   uv;
        logic [COUNTDOWN_W-1:0] cd;
        pick = $urandom_range(99);
        if (pick < 55)
            op = OP_TICK;
        else if (pick < 65)
            op = OP_LOAD_RES;
        else if (pick < 75)
            op = OP_STEP_ADJ;
        else if (pick < 87)
            op = OP_ARM_RTC;
        else if (pick < 95)
            op = OP_READ;
        else
            op = t_opcode'($urandom_range(int'(OP_SPARE_LAST), int'(OP_READ) + 1));
        if ($urandom_range(3) == 0)
            sd = $urandom;
        else
            sd = $urandom_range(10) - 5;
        case ($urandom_range(2))
            0:       uv = 21'($urandom);
            1:       uv = 21'($urandom_range(1999998) - 999999);
            default: uv = 21'($urandom_range(1200) - 600);
        endcase
        if ($urandom_range(3) == 0)
            cd = 20'($urandom);
        else
            cd = 20'($urandom_range(4000));
        send_cmd(op, sd, uv, cd);
    endtask

    initial begin
        // synchronous reset, asserted from time zero and released once
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part, reset configuration (step 500, trim off) ----
        send_cmd(OP_READ, 32'd0, 21'd0, 20'd0);
        send_cmd(OP_TICK, 32'($urandom), 21'($urandom), 20'($urandom));
        // unused opcodes behave as a read
        for (int k = int'(OP_READ) + 1; k <= int'(OP_SPARE_LAST); k++)
            send_cmd(t_opcode'(k), 32'($urandom), 21'($urandom), 20'($urandom));
        // zero countdown fires on the very next tick
        send_cmd(OP_ARM_RTC, 32'd0, 21'd0, 20'd0);
        send_cmd(OP_TICK, 32'd0, 21'd0, 20'd0);
        // re-arm while pending overwrites; 700 then fires on the second tick
        send_cmd(OP_ARM_RTC, 32'd0, 21'd0, 20'd1000);
        send_cmd(OP_ARM_RTC, 32'd0, 21'd0, 20'hFFFFF);
        send_cmd(OP_ARM_RTC, 32'd0, 21'd0, 20'd700);
        send_cmd(OP_TICK, 32'd0, 21'd0, 20'd0);
        send_cmd(OP_TICK, 32'd0, 21'd0, 20'd0);
        // residual extremes: slew clamps both ways, then a small one drains whole
        send_cmd(OP_LOAD_RES, 32'd0, 21'h0FFFFF, 20'd0);
        send_cmd(OP_TICK, 32'd0, 21'd0, 20'd0);
        send_cmd(OP_LOAD_RES, 32'd0, 21'h100000, 20'd0);
        send_cmd(OP_TICK, 32'd0, 21'd0, 20'd0);
        send_cmd(OP_LOAD_RES, 32'd0, 21'd100, 20'd0);
        send_cmd(OP_TICK, 32'd0, 21'd0, 20'd0);
        // step adjust saturating high, seconds extremes, then a forward carry
        send_cmd(OP_STEP_ADJ, 32'h7FFFFFFF, 21'h0FFFFF, 20'd0);
        send_cmd(OP_STEP_ADJ, 32'h7FFFFFFF, 21'h0FFFFF, 20'd0);
        send_cmd(OP_TICK, 32'd0, 21'd0, 20'd0);
        // saturating low, then a backward carry on the tick
        send_cmd(OP_STEP_ADJ, 32'h80000000, 21'h100000, 20'd0);
        send_cmd(OP_STEP_ADJ, 32'h80000000, 21'h100000, 20'd0);
        send_cmd(OP_TICK, 32'd0, 21'd0, 20'd0);
        send_cmd(OP_STEP_ADJ, 32'hFFFFFFFF, -21'sd999999, 20'd0);
        send_cmd(OP_STEP_ADJ, 32'd0, 21'sd999999, 20'd0);
        send_cmd(OP_READ, 32'd0, 21'd0, 20'd0);

        // ---- random chunks, each under its own configuration and idling ----
        for (int chunk = 0; chunk < CHUNKS; chunk++) begin
            case (chunk)
                0:       write_settings(16'hFFFF, 12'h7FF, 1'b1);  // widest step, full +trim
                1:       write_settings(16'h0000, 12'h800, 1'b1);  // no step, full -trim
                2:       write_settings(16'd500, 12'h000, 1'b0);
                default: write_settings($urandom_range(3) == 0 ? 16'($urandom)
                                                               : 16'($urandom_range(1200, 300)),
                                        12'($urandom), 1'($urandom));
            endcase
            send_idle_pct  = send_gap_pct[chunk % 4];
            recv_stall_pct = recv_gap_pct[chunk % 4];
            for (int n = 0; n < CHUNK_ITEMS; n++) begin
                // hold-off mid chunk: everything back before the next transfer
                if (n == CHUNK_ITEMS / 2)
                    drain_results();
                send_random_cmd();
            end
        end

        drain_results();
        recv_stall_pct = 0;
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("slewed_time_of_day_clock_top test passed");
        else
            $display("slewed_time_of_day_clock_top test failed");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/stdc_pkg.sv
rtl/core/slewed_time_of_day_clock_top.sv
tb/slewed_time_of_day_clock_checker.sv
tb/tb_slewed_time_of_day_clock_top.sv
